// ===== rtl/idiv64_pkg.sv =====
package idiv64_pkg;

	localparam int DATA_W  = 64;
	localparam int WORD_W  = 32;
	// One quotient bit is retired by each divide stage.
	localparam int STEPS   = DATA_W;
	// Operand stage, the divide stages and the result stage.
	localparam int LATENCY = STEPS + 2;

	typedef enum logic [1:0] {
		OP_DIV  = 2'd0,
		OP_DIVU = 2'd1,
		OP_REM  = 2'd2,
		OP_REMU = 2'd3
	} op_t;

	typedef struct packed {
		logic is_rem;
		logic invert;
		logic word;
		logic sext;
		logic zero;
	} ctrl_t;

endpackage

// ===== rtl/idiv64_step.sv =====
// One restoring step: brings down the next dividend bit, tries to subtract the
// divisor and shifts the resulting quotient bit into the low end of nq.
module idiv64_step (
	input  logic [idiv64_pkg::DATA_W-1:0] rem,
	input  logic [idiv64_pkg::DATA_W-1:0] nq,
	input  logic [idiv64_pkg::DATA_W-1:0] den,
	output logic [idiv64_pkg::DATA_W-1:0] rem_next,
	output logic [idiv64_pkg::DATA_W-1:0] nq_next
);

	logic [idiv64_pkg::DATA_W:0]   shifted;
	logic [idiv64_pkg::DATA_W+1:0] diff;
	logic                          fits;

	always_comb begin
		shifted  = {rem, nq[idiv64_pkg::DATA_W-1]};
		diff     = {1'b0, shifted} - {2'b00, den};
		fits     = ~diff[idiv64_pkg::DATA_W+1];
		rem_next = fits ? diff[idiv64_pkg::DATA_W-1:0] : shifted[idiv64_pkg::DATA_W-1:0];
		nq_next  = {nq[idiv64_pkg::DATA_W-2:0], fits};
	end

endmodule

// ===== rtl/integer_divider_64_unit.sv =====
// Pipelined 64-bit integer divide and remainder unit.
//
// A command is transferred at a rising clock edge at which start is high and
// busy is low. Busy never rises: the pipeline takes a new command in every
// cycle, so the throughput is one division per clock.
// The command carries operation (signed/unsigned divide, signed/unsigned
// remainder), word_mode (use only the low 32 bits of both operands), dividend
// and divisor.
// The result appears on quotient_or_remainder for exactly one cycle with done
// high, after passing through one operand stage that takes magnitudes, 64
// restoring stages of one quotient bit each (one 65-bit compare-subtract per
// stage sets the clock), and one stage that restores the sign and extends word
// results. Results leave in command order.
// The receiver cannot hold results off; none is needed since nothing stalls.
// A zero divisor gives 0. The most negative value divided by -1 gives the
// most negative value, with remainder 0.
// Reset clears the valid bits of every stage at once, so commands still in
// flight are dropped and done stays low until a new command comes through.
module integer_divider_64_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic        word_mode,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic [63:0] quotient_or_remainder,
	output logic        done
);

	localparam int DW = idiv64_pkg::DATA_W;
	localparam int WW = idiv64_pkg::WORD_W;
	localparam int NS = idiv64_pkg::STEPS;

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---------------------------------------------------------------------
	// Operand stage: mask word operands, take magnitudes, note signs.
	// ---------------------------------------------------------------------
	logic [DW-1:0]     a_m, b_m, ma, mb;
	logic              is_unsigned, neg_a, neg_b;
	idiv64_pkg::ctrl_t ctrl_in;

	always_comb begin
		is_unsigned = (operation == idiv64_pkg::OP_DIVU) ||
			(operation == idiv64_pkg::OP_REMU);
		if (word_mode) begin
			a_m   = {{(DW-WW){1'b0}}, dividend[WW-1:0]};
			b_m   = {{(DW-WW){1'b0}}, divisor[WW-1:0]};
			neg_a = !is_unsigned && dividend[WW-1];
			neg_b = !is_unsigned && divisor[WW-1];
		end else begin
			a_m   = dividend;
			b_m   = divisor;
			neg_a = !is_unsigned && dividend[DW-1];
			neg_b = !is_unsigned && divisor[DW-1];
		end
		ma = neg_a ? (~a_m + 1'b1) : a_m;
		mb = neg_b ? (~b_m + 1'b1) : b_m;
		if (word_mode) begin
			ma[DW-1:WW] = '0;
			mb[DW-1:WW] = '0;
		end
		ctrl_in.is_rem = (operation == idiv64_pkg::OP_REM) ||
			(operation == idiv64_pkg::OP_REMU);
		ctrl_in.invert = ctrl_in.is_rem ? neg_a : (neg_a ^ neg_b);
		ctrl_in.word   = word_mode;
		ctrl_in.sext   = word_mode && !is_unsigned;
		// Negation keeps zero as zero, so the masked divisor decides.
		ctrl_in.zero   = (b_m == '0);
	end

	logic              valid_s1;
	logic [DW-1:0]     ma_s1, mb_s1;
	idiv64_pkg::ctrl_t ctrl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1   <= ma;
		mb_s1   <= mb;
		ctrl_s1 <= ctrl_in;
	end

	// ---------------------------------------------------------------------
	// Divide stages: each retires one quotient bit. The dividend shifts out
	// of the top of nq while the quotient fills it from the bottom.
	// ---------------------------------------------------------------------
	logic [NS-1:0]     valid_s2;
	logic [DW-1:0]     rem_s2  [NS];
	logic [DW-1:0]     nq_s2   [NS];
	logic [DW-1:0]     den_s2  [NS];
	idiv64_pkg::ctrl_t ctrl_s2 [NS];
	logic [DW-1:0]     rem_nx  [NS];
	logic [DW-1:0]     nq_nx   [NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= '0;
		end else begin
			valid_s2 <= {valid_s2[NS-2:0], valid_s1};
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_step
		if (k == 0) begin : g_first
			idiv64_step u_step (
				.rem      ('0),
				.nq       (ma_s1),
				.den      (mb_s1),
				.rem_next (rem_nx[k]),
				.nq_next  (nq_nx[k])
			);

			always_ff @(posedge clk) begin
				den_s2[k]  <= mb_s1;
				ctrl_s2[k] <= ctrl_s1;
			end
		end else begin : g_next
			idiv64_step u_step (
				.rem      (rem_s2[k-1]),
				.nq       (nq_s2[k-1]),
				.den      (den_s2[k-1]),
				.rem_next (rem_nx[k]),
				.nq_next  (nq_nx[k])
			);

			always_ff @(posedge clk) begin
				den_s2[k]  <= den_s2[k-1];
				ctrl_s2[k] <= ctrl_s2[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s2[k] <= rem_nx[k];
			nq_s2[k]  <= nq_nx[k];
		end
	end

	// ---------------------------------------------------------------------
	// Result stage: pick quotient or remainder, restore the sign, extend word
	// results; a zero divisor gives 0. The last step leaves the whole quotient in nq.
	// ---------------------------------------------------------------------
	idiv64_pkg::ctrl_t ctrl_l;
	logic [DW-1:0]     pick, signed_res, final_res;

	always_comb begin
		ctrl_l     = ctrl_s2[NS-1];
		pick       = ctrl_l.is_rem ? rem_s2[NS-1] : nq_s2[NS-1];
		signed_res = ctrl_l.invert ? (~pick + 1'b1) : pick;
		final_res  = signed_res;
		if (ctrl_l.word) begin
			final_res[DW-1:WW] = {(DW-WW){ctrl_l.sext && signed_res[WW-1]}};
		end
		if (ctrl_l.zero) begin
			final_res = '0;
		end
	end

	logic          valid_s3;
	logic [DW-1:0] res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		res_s3 <= final_res;
	end

	assign done                  = valid_s3;
	assign quotient_or_remainder = res_s3;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------

	// Every transferred command comes out after the fixed latency.
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(idiv64_pkg::LATENCY) done)
		else $error("command did not complete after the pipeline latency");

	// No result appears without a command transferred one latency earlier.
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, idiv64_pkg::LATENCY))
		else $error("result without a matching command");

	// A full-width command with a zero divisor yields zero.
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(accept && !word_mode && (divisor == '0), idiv64_pkg::LATENCY))
		|-> (quotient_or_remainder == '0))
		else $error("zero divisor did not give zero");

endmodule
